/* src/pls_pkg.sv */
package pls_pkg;

   localparam int CAPACITY_DEFAULT = 16;
   localparam int DATA_WIDTH       = 32;
   localparam int POS_WIDTH        = 5;
   localparam int LEN_WIDTH        = 5;

   typedef enum logic [1:0] {
      CMD_GET    = 2'd0,
      CMD_MODIFY = 2'd1,
      CMD_INSERT = 2'd2,
      CMD_DELETE = 2'd3
   } cmd_type;

   typedef enum logic [1:0] {
      ST_OK    = 2'd0,
      ST_RANGE = 2'd1,
      ST_FULL  = 2'd2
   } status_type;

   // broadcast to every cell of the row
   typedef struct packed {
      logic                   en;
      cmd_type                cmd;
      logic [POS_WIDTH-1:0]   slot;
      logic [DATA_WIDTH-1:0]  value;
   } cell_ctrl_type;

endpackage

/* src/pls_cell.sv */
module pls_cell #(
   parameter int INDEX = 0
) (
   input  logic                              clock,
   input  pls_pkg::cell_ctrl_type            ctrl,
   input  logic [pls_pkg::DATA_WIDTH-1:0]    left_value,
   input  logic [pls_pkg::DATA_WIDTH-1:0]    right_value,
   output logic [pls_pkg::DATA_WIDTH-1:0]    value_out,
   output logic [pls_pkg::DATA_WIDTH-1:0]    read_out
);

   logic [pls_pkg::DATA_WIDTH-1:0] value_ff;
   logic [pls_pkg::DATA_WIDTH-1:0] value_in;
   logic                           hit;
   logic                           above;

   always_comb begin
      hit      = (INDEX == int'(ctrl.slot));
      above    = (INDEX > int'(ctrl.slot));
      value_in = value_ff;
      if (ctrl.en) begin
         case (ctrl.cmd)
            pls_pkg::CMD_MODIFY: begin
               if (hit) value_in = ctrl.value;
            end
            pls_pkg::CMD_INSERT: begin
               if (hit) value_in = ctrl.value;
               else if (above) value_in = left_value;
            end
            pls_pkg::CMD_DELETE: begin
               if (hit || above) value_in = right_value;
            end
            default: value_in = value_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      value_ff <= value_in;
   end

   assign value_out = value_ff;
   assign read_out  = hit ? value_ff : '0;

endmodule

/* src/positional_list_store.sv */
// Ordered list of signed 32-bit words addressed by 1-based position, held in a
// row of CAPACITY cells that all shift or load in the same cycle. A request
// (get, modify, insert or delete) is taken and its result appears on the rsp
// side on the next edge, so one request per cycle is sustained while results
// are taken; the only limit is the single output register. Positions 1 to list
// length (+1 for an insert) are valid. No clearing pass is needed after reset.
module positional_list_store #(
   parameter int CAPACITY = pls_pkg::CAPACITY_DEFAULT
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [39:0] req_tdata,   // command[1:0], position[6:2], value[38:7], zero pad
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [39:0] rsp_tdata    // status[1:0], read_value[33:2], list_length[38:34], pad
);

   localparam int CW = $clog2(CAPACITY + 1);
   localparam int LW = (CW > pls_pkg::POS_WIDTH + 1) ? CW : pls_pkg::POS_WIDTH + 1;
   localparam int DW = pls_pkg::DATA_WIDTH;

   pls_pkg::cmd_type                 cmd;
   logic [pls_pkg::POS_WIDTH-1:0]    pos;
   logic [DW-1:0]                    val;
   logic [LW-1:0]                    pos_ext;
   logic [LW-1:0]                    cnt_ext;
   logic                             req_fire;
   logic                             op_ok;
   pls_pkg::status_type              status_in;
   pls_pkg::cell_ctrl_type           ctrl;
   logic [DW-1:0]                    cell_value [CAPACITY];
   logic [DW-1:0]                    cell_read  [CAPACITY];
   logic [DW-1:0]                    rd_any;

   logic [CW-1:0]                    count_ff, count_in;
   logic                             rsp_valid_ff, rsp_valid_in;
   pls_pkg::status_type              status_ff;
   logic [DW-1:0]                    rd_ff, rd_in;

   assign cmd     = pls_pkg::cmd_type'(req_tdata[1:0]);
   assign pos     = req_tdata[6:2];
   assign val     = req_tdata[38:7];
   assign pos_ext = LW'(pos);
   assign cnt_ext = LW'(count_ff);

   assign req_tready = !rsp_valid_ff || rsp_tready;
   assign req_fire   = req_tvalid && req_tready;

   always_comb begin
      status_in = pls_pkg::ST_OK;
      if (cmd == pls_pkg::CMD_INSERT) begin
         if (pos == '0 || pos_ext > cnt_ext + LW'(1)) status_in = pls_pkg::ST_RANGE;
         else if (count_ff == CW'(CAPACITY)) status_in = pls_pkg::ST_FULL;
      end else if (pos == '0 || pos_ext > cnt_ext) begin
         status_in = pls_pkg::ST_RANGE;
      end
      op_ok = (status_in == pls_pkg::ST_OK);
   end

   always_comb begin
      ctrl.en    = req_fire && op_ok;
      ctrl.cmd   = cmd;
      ctrl.slot  = pos - pls_pkg::POS_WIDTH'(1);
      ctrl.value = val;
   end

   for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
      logic [DW-1:0] left_value;
      logic [DW-1:0] right_value;
      if (i == 0) begin : g_first
         assign left_value = '0;
      end else begin : g_inner_left
         assign left_value = cell_value[i-1];
      end
      if (i == CAPACITY - 1) begin : g_last
         assign right_value = '0;
      end else begin : g_inner_right
         assign right_value = cell_value[i+1];
      end
      pls_cell #(
         .INDEX (i)
      ) u_cell (
         .clock       (clock),
         .ctrl        (ctrl),
         .left_value  (left_value),
         .right_value (right_value),
         .value_out   (cell_value[i]),
         .read_out    (cell_read[i])
      );
   end

   always_comb begin
      rd_any = '0;
      for (int i = 0; i < CAPACITY; i++) begin
         rd_any = rd_any | cell_read[i];
      end
      rd_in = rd_ff;
      count_in = count_ff;
      rsp_valid_in = rsp_valid_ff;
      if (rsp_valid_ff && rsp_tready) rsp_valid_in = 1'b0;
      if (req_fire) begin
         rsp_valid_in = 1'b1;
         rd_in = '0;
         if (op_ok) begin
            case (cmd)
               pls_pkg::CMD_GET:    rd_in = rd_any;
               pls_pkg::CMD_INSERT: count_in = count_ff + CW'(1);
               pls_pkg::CMD_DELETE: begin
                  rd_in    = rd_any;
                  count_in = count_ff - CW'(1);
               end
               default: rd_in = '0;
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      if (req_fire) begin
         status_ff <= status_in;
      end
      rd_ff <= rd_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {1'b0, pls_pkg::LEN_WIDTH'(count_ff), rd_ff, status_ff};

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CW'(CAPACITY))
      else $error("list count beyond capacity");

   a_insert_grows: assert property (@(posedge clock) disable iff (reset)
      (req_fire && op_ok && cmd == pls_pkg::CMD_INSERT)
      |=> count_ff == CW'($past(count_ff) + CW'(1)))
      else $error("insert did not grow the list");

   a_fail_keeps: assert property (@(posedge clock) disable iff (reset)
      (req_fire && !op_ok) |=> $stable(count_ff))
      else $error("failed request changed the list length");

   a_error_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && status_ff != pls_pkg::ST_OK) |-> rd_ff == '0)
      else $error("error result carries data");

endmodule
